// ----- design/wat_pkg.sv -----
// ----------------------------------------------------------------------------
// wat_pkg: shared types and constants for the windowed auto-range tracker
// Holds the sequencer state type, field widths, default bounds and the
// reciprocal used to divide a span by ten.
// ----------------------------------------------------------------------------
package wat_pkg;

    // Field widths of one input item and one result item.
    localparam int IN_W   = 20;
    localparam int OUT_W  = 21;
    localparam int CNT_W  = 8;

    // A span of two 20-bit signed samples is never negative and fits 20 bits.
    localparam int SPAN_W = 20;

    // span / 10 is floor(span * RECIP_10 / 2**RECIP_SHIFT), exact for span < 2**22.
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_10 = 21'd1677722;
    localparam int PROD_W  = SPAN_W + RECIP_W;
    localparam int TENTH_W = 17;

    // Bounds used when auto ranging is off.
    localparam logic signed [OUT_W-1:0] DEF_P_LOW  = -21'sd10000;
    localparam logic signed [OUT_W-1:0] DEF_P_HIGH = 21'sd0;
    localparam logic signed [OUT_W-1:0] DEF_C_LOW  = 21'sd0;
    localparam logic signed [OUT_W-1:0] DEF_C_HIGH = 21'sd500;

    // Padding for flat spans.
    localparam logic signed [OUT_W-1:0] FLAT_P_PAD  = 21'sd500;
    localparam logic signed [OUT_W-1:0] FLAT_C_SPAN = 21'sd100;

    // Configuration register indexes.
    localparam logic REG_AUTO_RANGE = 1'b0;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PSPAN,
        ST_PMUL,
        ST_PADJ,
        ST_CSPAN,
        ST_CMUL,
        ST_CADJ,
        ST_DONE
    } t_state;

endpackage

// ----- design/wat_ram.sv -----
// ----------------------------------------------------------------------------
// wat_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module wat_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/windowed_autorange_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// windowed_autorange_tracker_unit: sliding-window min/max display ranging
// Stores each pressure/current pair in a ring and derives display bounds
// from the minimum and maximum of the held pairs, widened by a tenth or padded when flat.
//
//   Channel   Direction  Handshake                 Payload
//   s_axis    in         tvalid/tready             pressure, current samples
//   m_axis    out        tvalid/tready             bounds and pairs held
//   apb       in/out     psel/penable/pwrite       auto_range_on at address 0
//
// For each item the scan reads the held pairs (at most WINDOW) one per cycle
// from the ring RAM, then one shared subtractor and a reciprocal multiply work
// out both widened spans in six steps.
// With auto ranging off an item goes from idle straight to the done state.
// Reset is synchronous; after it the ring is empty and auto ranging is on.
// The input side is ready only while the sequencer is idle; a finished result
// waits in the output register while the next item is already at work.
// ----------------------------------------------------------------------------
module windowed_autorange_tracker_unit #(
    parameter int WINDOW = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [19:0] pressure_sample, [39:20] current_sample
    input  logic [39:0] s_axis_tdata,
    // Result item stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [20:0] pressure_low, [41:21] pressure_high, [62:42] current_low,
    // [83:63] current_high, [91:84] points_held, [95:92] zero
    output logic [95:0] m_axis_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW     = $clog2(WINDOW);
    localparam int CW     = $clog2(WINDOW + 1);
    localparam int IN_W   = wat_pkg::IN_W;
    localparam int OUT_W  = wat_pkg::OUT_W;
    localparam int PAIR_W = 2 * IN_W;

    // Control registers.
    wat_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_slot, n_slot;
    logic            r_filled, n_filled;
    logic [CW-1:0]   r_held, n_held;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_rd_vld, n_rd_vld;
    logic            r_first, n_first;
    logic            r_m_valid, n_m_valid;
    logic            r_auto;

    // Datapath registers.
    logic signed [IN_W-1:0]      r_pmin, n_pmin, r_pmax, n_pmax;
    logic signed [IN_W-1:0]      r_cmin, n_cmin, r_cmax, n_cmax;
    logic [wat_pkg::SPAN_W-1:0]  r_span, n_span;
    logic [wat_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic signed [OUT_W-1:0]     r_plo, n_plo, r_phi, n_phi;
    logic signed [OUT_W-1:0]     r_clo, n_clo, r_chi, n_chi;
    logic [95:0]                 r_out, n_out;

    // Ring RAM signals.
    logic              ram_we;
    logic [PAIR_W-1:0] ram_rdata;
    logic signed [IN_W-1:0] rd_p, rd_c;

    // Shared arithmetic unit operands.
    logic signed [IN_W-1:0]  op_hi, op_lo;
    logic signed [IN_W:0]    diff;
    logic signed [OUT_W-1:0] tenth;
    logic signed [OUT_W-1:0] base_lo, base_hi;
    logic signed [OUT_W-1:0] wide_lo, wide_hi;

    logic s_acc, m_acc, cfg_wr;

    assign s_acc  = s_axis_tvalid && s_axis_tready;
    assign m_acc  = m_axis_tvalid && m_axis_tready;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Ring of stored pairs: current in the upper half, pressure in the lower.
    assign ram_we = s_acc;

    wat_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (s_axis_tdata[PAIR_W-1:0]),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign rd_p = signed'(ram_rdata[IN_W-1:0]);
    assign rd_c = signed'(ram_rdata[PAIR_W-1:IN_W]);

    // Shared unit: span subtract, tenth extraction and bound adjust.
    always_comb begin
        if (r_state == wat_pkg::ST_CSPAN) begin
            op_hi = r_cmax;
            op_lo = r_cmin;
        end else begin
            op_hi = r_pmax;
            op_lo = r_pmin;
        end
        if (r_state == wat_pkg::ST_CADJ) begin
            base_lo = OUT_W'(r_cmin);
            base_hi = OUT_W'(r_cmax);
        end else begin
            base_lo = OUT_W'(r_pmin);
            base_hi = OUT_W'(r_pmax);
        end
        diff    = (IN_W + 1)'(op_hi) - (IN_W + 1)'(op_lo);
        tenth   = signed'(OUT_W'(r_prod[wat_pkg::RECIP_SHIFT +: wat_pkg::TENTH_W]));
        wide_lo = base_lo - tenth;
        wide_hi = base_hi + tenth;
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_filled  = r_filled;
        n_held    = r_held;
        n_idx     = r_idx;
        n_rd_vld  = 1'b0;
        n_first   = r_first;
        n_m_valid = r_m_valid;
        n_pmin    = r_pmin;
        n_pmax    = r_pmax;
        n_cmin    = r_cmin;
        n_cmax    = r_cmax;
        n_span    = r_span;
        n_prod    = r_prod;
        n_plo     = r_plo;
        n_phi     = r_phi;
        n_clo     = r_clo;
        n_chi     = r_chi;
        n_out     = r_out;

        // The result register frees up when its item is taken.
        if (m_acc) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            wat_pkg::ST_IDLE: begin
                if (s_acc) begin
                    // Store the pair and advance the ring.
                    if (r_slot == AW'(WINDOW - 1)) begin
                        n_slot   = '0;
                        n_filled = 1'b1;
                        n_held   = CW'(WINDOW);
                    end else begin
                        n_slot   = r_slot + 1'b1;
                        n_held   = r_filled ? CW'(WINDOW) : CW'(r_slot) + 1'b1;
                    end
                    n_plo   = wat_pkg::DEF_P_LOW;
                    n_phi   = wat_pkg::DEF_P_HIGH;
                    n_clo   = wat_pkg::DEF_C_LOW;
                    n_chi   = wat_pkg::DEF_C_HIGH;
                    n_idx   = '0;
                    n_first = 1'b1;
                    n_state = r_auto ? wat_pkg::ST_SCAN : wat_pkg::ST_DONE;
                end
            end
            wat_pkg::ST_SCAN: begin
                // Issue one read per cycle; fold in the returned data in the next cycle.
                if (r_idx < r_held) begin
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    n_first = 1'b0;
                    if (r_first || rd_p < r_pmin) n_pmin = rd_p;
                    if (r_first || rd_p > r_pmax) n_pmax = rd_p;
                    if (r_first || rd_c < r_cmin) n_cmin = rd_c;
                    if (r_first || rd_c > r_cmax) n_cmax = rd_c;
                end
                if (!(r_idx < r_held) && !r_rd_vld) begin
                    n_state = wat_pkg::ST_PSPAN;
                end
            end
            wat_pkg::ST_PSPAN: begin
                n_span  = wat_pkg::SPAN_W'(unsigned'(diff));
                n_state = wat_pkg::ST_PMUL;
            end
            wat_pkg::ST_PMUL: begin
                n_prod  = wat_pkg::PROD_W'(r_span) * wat_pkg::PROD_W'(wat_pkg::RECIP_10);
                n_state = wat_pkg::ST_PADJ;
            end
            wat_pkg::ST_PADJ: begin
                if (r_span == '0) begin
                    n_plo = base_lo - wat_pkg::FLAT_P_PAD;
                    n_phi = base_hi + wat_pkg::FLAT_P_PAD;
                end else begin
                    n_plo = wide_lo;
                    n_phi = wide_hi;
                end
                n_state = wat_pkg::ST_CSPAN;
            end
            wat_pkg::ST_CSPAN: begin
                n_span  = wat_pkg::SPAN_W'(unsigned'(diff));
                n_state = wat_pkg::ST_CMUL;
            end
            wat_pkg::ST_CMUL: begin
                n_prod  = wat_pkg::PROD_W'(r_span) * wat_pkg::PROD_W'(wat_pkg::RECIP_10);
                n_state = wat_pkg::ST_CADJ;
            end
            wat_pkg::ST_CADJ: begin
                if (r_span == '0) begin
                    n_clo = base_lo;
                    n_chi = base_lo + wat_pkg::FLAT_C_SPAN;
                end else begin
                    // The widened current floor never drops below zero.
                    n_clo = wide_lo[OUT_W-1] ? '0 : wide_lo;
                    n_chi = wide_hi;
                end
                n_state = wat_pkg::ST_DONE;
            end
            wat_pkg::ST_DONE: begin
                // Hand the result over once the output register is free.
                if (!r_m_valid || m_axis_tready) begin
                    n_out = {4'b0000, wat_pkg::CNT_W'(r_held),
                             r_chi, r_clo, r_phi, r_plo};
                    n_m_valid = 1'b1;
                    n_state   = wat_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wat_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wat_pkg::ST_IDLE;
            r_slot    <= '0;
            r_filled  <= 1'b0;
            r_held    <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_first   <= 1'b1;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_slot    <= n_slot;
            r_filled  <= n_filled;
            r_held    <= n_held;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_first   <= n_first;
            r_m_valid <= n_m_valid;
        end
    end

    // Configuration register: only bit 0 of a write with paddr[2] low (addresses 0 to 3) is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_auto <= 1'b1;
        end else if (cfg_wr && paddr[2] == wat_pkg::REG_AUTO_RANGE) begin
            r_auto <= pwdata[0];
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_pmin <= n_pmin;
        r_pmax <= n_pmax;
        r_cmin <= n_cmin;
        r_cmax <= n_cmax;
        r_span <= n_span;
        r_prod <= n_prod;
        r_plo  <= n_plo;
        r_phi  <= n_phi;
        r_clo  <= n_clo;
        r_chi  <= n_chi;
        r_out  <= n_out;
    end

    // Port outputs.
    assign s_axis_tready = (r_state == wat_pkg::ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_out;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == wat_pkg::REG_AUTO_RANGE) ? {31'd0, r_auto} : 32'd0;

`ifndef NO_ASSERTIONS
    // An accepted item keeps the block busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // The held count never exceeds the window and is full once the ring wrapped.
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held <= CW'(WINDOW)) && (!r_filled || r_held == CW'(WINDOW)))
        else $error("held count out of range");

    // The scan never reads past the held pairs.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wat_pkg::ST_SCAN) |-> (r_idx <= r_held))
        else $error("scan index beyond held count");

    // A new result only appears when the sequencer finishes an item.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> ($past(r_state) == wat_pkg::ST_DONE))
        else $error("result appeared outside completion");

    // The ring slot never reaches the window size.
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= AW'(WINDOW - 1))
        else $error("write slot out of range");
`endif

endmodule
